### rtl/sha_pkg.sv
// Package: SHA-256 constants, types and round functions.
`timescale 1ns / 1ps
package sha_pkg;

    localparam int BlockBytes = 64;
    localparam int Rounds     = 64;

    typedef logic [31:0] word_t;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_PAD80  = 7'b0000010,
        ST_PADZ   = 7'b0000100,
        ST_LEN    = 7'b0001000,
        ST_COMP   = 7'b0010000,
        ST_EMIT   = 7'b0100000,
        ST_FIN    = 7'b1000000
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic       wr_byte;      // write byte into buffer at wr_pos
        logic [5:0] wr_pos;
        logic [7:0] wr_data;
        logic       add_len;      // bit length += 8
        logic       comp_start;   // load working words before round 0
        logic       comp_round;   // run one round
        logic [5:0] round;
        logic       comp_fold;    // chaining += working
        logic       init;         // restart message
        logic       len_byte;     // write length byte at wr_pos
    } dp_cmd_t;

    localparam word_t InitHash [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t RoundK [64] = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
        32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
        32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
        32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
        32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
        32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
        32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
        32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
        32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2
    };

    localparam logic [7:0] PadByte = 8'h80;

    function automatic word_t ror(input word_t x, input int n);
        ror = (x >> n) | (x << (32 - n));
    endfunction

    function automatic word_t sig0(input word_t x);
        sig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t sig1(input word_t x);
        sig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
    endfunction

    function automatic word_t bsig0(input word_t x);
        bsig0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
    endfunction

    function automatic word_t bsig1(input word_t x);
        bsig1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
    endfunction

endpackage

### rtl/sha_datapath.sv
// SHA-256 datapath: block buffer, schedule, round unit, chaining words, length.
`timescale 1ns / 1ps
module sha_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  sha_pkg::dp_cmd_t  cmd,
    input  logic [1:0]        part_sel,
    output logic [63:0]       part_data
);

    sha_pkg::word_t      buf_reg [16];
    sha_pkg::word_t      w_reg [16];
    sha_pkg::word_t      v_reg [8];
    sha_pkg::word_t      h_reg [8];
    logic [63:0]         len_reg;

    sha_pkg::word_t wt;
    sha_pkg::word_t w_new;
    sha_pkg::word_t x1;
    sha_pkg::word_t x2;
    logic [7:0]     len_b;

    assign w_new = w_reg[0] + sha_pkg::sig0(w_reg[1]) + w_reg[9] + sha_pkg::sig1(w_reg[14]);
    assign wt = (cmd.round < 6'd16) ? buf_reg[cmd.round[3:0]] : w_new;
    assign x1 = v_reg[7] + sha_pkg::bsig1(v_reg[4]) +
                ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6])) +
                sha_pkg::RoundK[cmd.round] + wt;
    assign x2 = sha_pkg::bsig0(v_reg[0]) +
                ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    assign len_b = len_reg[8 * (7 - cmd.wr_pos[2:0]) +: 8];

    always_ff @(posedge clk)
    begin
        if (cmd.wr_byte)
        begin
            buf_reg[cmd.wr_pos[5:2]][8 * (3 - cmd.wr_pos[1:0]) +: 8] <=
                cmd.len_byte ? len_b : cmd.wr_data;
        end
        if (cmd.comp_start)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= h_reg[i];
            end
        end
        else if (cmd.comp_round)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= wt;
            v_reg[0] <= x1 + x2;
            v_reg[1] <= v_reg[0];
            v_reg[2] <= v_reg[1];
            v_reg[3] <= v_reg[2];
            v_reg[4] <= v_reg[3] + x1;
            v_reg[5] <= v_reg[4];
            v_reg[6] <= v_reg[5];
            v_reg[7] <= v_reg[6];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= sha_pkg::InitHash[i];
            end
            len_reg <= '0;
        end
        else if (cmd.init)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= sha_pkg::InitHash[i];
            end
            len_reg <= '0;
        end
        else
        begin
            if (cmd.comp_fold)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    h_reg[i] <= h_reg[i] + v_reg[i];
                end
            end
            if (cmd.add_len)
            begin
                len_reg <= len_reg + 64'd8;
            end
        end
    end

    assign part_data = {h_reg[{part_sel, 1'b0}], h_reg[{part_sel, 1'b1}]};

endmodule

### rtl/sha_ctrl.sv
// SHA-256 controller: input transfer, padding sequence, rounds, digest output.
`timescale 1ns / 1ps
module sha_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        in_byte,
    input  logic              in_present,
    input  logic              in_end,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        part_sel,
    output sha_pkg::dp_cmd_t  cmd
);

    sha_pkg::state_t state_reg, state_next;
    logic [5:0] pos_reg, pos_next;
    logic [6:0] rnd_reg, rnd_next;
    logic [1:0] part_reg, part_next;
    logic       fin_reg, fin_next;     // message end pending
    logic       two_reg, two_next;     // padding needs a second block
    logic       acc;

    assign in_stall = (state_reg != sha_pkg::ST_IDLE);
    assign acc = in_valid && !in_stall;
    assign out_valid = (state_reg == sha_pkg::ST_EMIT);
    assign part_sel = part_reg;

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        rnd_next   = rnd_reg;
        part_next  = part_reg;
        fin_next   = fin_reg;
        two_next   = two_reg;
        cmd        = '0;
        cmd.wr_pos = pos_reg;
        cmd.round  = rnd_reg[5:0];
        unique case (state_reg)
            sha_pkg::ST_IDLE:
            begin
                if (acc)
                begin
                    fin_next = in_end;
                    if (in_present)
                    begin
                        cmd.wr_byte = 1'b1;
                        cmd.wr_data = in_byte;
                        cmd.add_len = 1'b1;
                        pos_next = pos_reg + 6'd1;
                        if (pos_reg == 6'd63)
                        begin
                            state_next = sha_pkg::ST_COMP;
                            rnd_next = '0;
                            cmd.comp_start = 1'b1;
                        end
                        else if (in_end)
                        begin
                            state_next = sha_pkg::ST_PAD80;
                        end
                    end
                    else if (in_end)
                    begin
                        state_next = sha_pkg::ST_PAD80;
                    end
                end
            end
            sha_pkg::ST_PAD80:
            begin
                cmd.wr_byte = 1'b1;
                cmd.wr_data = sha_pkg::PadByte;
                two_next = (pos_reg > 6'd55);
                pos_next = pos_reg + 6'd1;
                state_next = (pos_reg == 6'd63) ? sha_pkg::ST_COMP : sha_pkg::ST_PADZ;
                if (pos_reg == 6'd63)
                begin
                    cmd.comp_start = 1'b1;
                    rnd_next = '0;
                end
            end
            sha_pkg::ST_PADZ:
            begin
                if (!two_reg && pos_reg == 6'd56)
                begin
                    state_next = sha_pkg::ST_LEN;
                end
                else
                begin
                    cmd.wr_byte = 1'b1;
                    cmd.wr_data = 8'h00;
                    pos_next = pos_reg + 6'd1;
                    if (pos_reg == 6'd63)
                    begin
                        state_next = sha_pkg::ST_COMP;
                        cmd.comp_start = 1'b1;
                        rnd_next = '0;
                    end
                end
            end
            sha_pkg::ST_LEN:
            begin
                cmd.wr_byte = 1'b1;
                cmd.len_byte = 1'b1;
                pos_next = pos_reg + 6'd1;
                if (pos_reg == 6'd63)
                begin
                    state_next = sha_pkg::ST_COMP;
                    cmd.comp_start = 1'b1;
                    rnd_next = '0;
                end
            end
            sha_pkg::ST_COMP:
            begin
                if (rnd_reg == 7'd64)
                begin
                    cmd.comp_fold = 1'b1;
                    if (!fin_reg)
                    begin
                        state_next = sha_pkg::ST_IDLE;
                    end
                    else if (two_reg)
                    begin
                        two_next = 1'b0;
                        state_next = sha_pkg::ST_PADZ;
                    end
                    else if (pos_reg == 6'd0 && rnd_reg == 7'd64 && !two_reg)
                    begin
                        state_next = sha_pkg::ST_FIN;
                    end
                end
                else
                begin
                    cmd.comp_round = 1'b1;
                    rnd_next = rnd_reg + 7'd1;
                end
            end
            sha_pkg::ST_FIN:
            begin
                // go to digest output, starting at part 0
                state_next = sha_pkg::ST_EMIT;
                part_next = '0;
            end
            sha_pkg::ST_EMIT:
            begin
                if (!out_stall)
                begin
                    part_next = part_reg + 2'd1;
                    if (part_reg == 2'd3)
                    begin
                        cmd.init = 1'b1;
                        fin_next = 1'b0;
                        state_next = sha_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = sha_pkg::ST_IDLE;
            end
        endcase
    end

    // after a data block fills while the end is pending, padding starts next
    sha_pkg::state_t state_fix;
    logic padded_reg, padded_next;
    always_comb
    begin
        state_fix = state_next;
        padded_next = padded_reg;
        if (state_reg == sha_pkg::ST_PAD80)
        begin
            padded_next = 1'b1;
        end
        if (state_reg == sha_pkg::ST_EMIT && state_next == sha_pkg::ST_IDLE)
        begin
            padded_next = 1'b0;
        end
        if (state_reg == sha_pkg::ST_COMP && rnd_reg == 7'd64 && fin_reg && !two_reg)
        begin
            state_fix = padded_reg ? sha_pkg::ST_FIN : sha_pkg::ST_PAD80;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= sha_pkg::ST_IDLE;
            pos_reg    <= '0;
            rnd_reg    <= '0;
            part_reg   <= '0;
            fin_reg    <= 1'b0;
            two_reg    <= 1'b0;
            padded_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_fix;
            pos_reg    <= pos_next;
            rnd_reg    <= rnd_next;
            part_reg   <= part_next;
            fin_reg    <= fin_next;
            two_reg    <= two_next;
            padded_reg <= padded_next;
        end
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != sha_pkg::ST_IDLE) |-> !acc)
        else $error("input transfer while busy");
    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sha_pkg::ST_COMP) |-> (rnd_reg <= 7'd64))
        else $error("round count out of range");
    a_emit_fin: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> fin_reg)
        else $error("digest without message end");
    a_last_init: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.init |=> (pos_reg == 6'd0 && state_reg == sha_pkg::ST_IDLE))
        else $error("restart did not clear position");
`endif

endmodule

### rtl/sha256_stream_hasher.sv
// Streaming SHA-256 hasher top level.
`timescale 1ns / 1ps
// One byte transfer per cycle is taken while idle; a byte that completes a
// 64-byte block starts a compression in the single shared round unit (one
// round per cycle plus the fold). At message end the controller writes padding
// one byte per cycle: the 0x80 byte, zero fill, a step with no write to
// switch to the length, then eight length bytes. Each padded block is then
// compressed; an end with 56 or more bytes in the buffer needs two padded
// blocks. After a finishing state the four 64-bit digest parts are presented,
// part 0 first, one per cycle unless stalled, and the block restarts for the
// next message. Input is stalled during every compression, padding, finishing
// and digest output.
module sha256_stream_hasher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] digest_part,
    output logic [1:0]  part_index,
    output logic        last_part
);

    sha_pkg::dp_cmd_t cmd;
    logic [1:0]       sel;

    sha_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (data_byte),
        .in_present (byte_present),
        .in_end     (end_of_message),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .part_sel   (sel),
        .cmd        (cmd)
    );

    sha_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .part_sel  (sel),
        .part_data (digest_part)
    );

    assign part_index = sel;
    assign last_part  = (sel == 2'd3);

endmodule

### tb/sv/sha256_stream_hasher_tb.sv
// Testbench for the streaming SHA-256 hasher: scoreboard with its own digest predictor.
`timescale 1ns / 1ps
module sha256_stream_hasher_tb;

    typedef struct packed {
        logic [63:0] part;
        logic [1:0]  idx;
        logic        last;
    } digest_rec_t;

    class digest_board;
        sha_pkg::word_t hash_state [8];
        logic [7:0]  blk [64];
        int unsigned fill;
        logic [63:0] bit_count;
        digest_rec_t pending [$];
        int          errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            for (int i = 0; i < 8; i++)
            begin
                hash_state[i] = sha_pkg::InitHash[i];
            end
            fill = 0;
            bit_count = '0;
        endfunction

        function sha_pkg::word_t rotr(sha_pkg::word_t x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void compress();
            sha_pkg::word_t w [16];
            sha_pkg::word_t v [8];
            sha_pkg::word_t wt, s0, s1, t1, t2;
            for (int i = 0; i < 8; i++)
            begin
                v[i] = hash_state[i];
            end
            for (int t = 0; t < 64; t++)
            begin
                if (t < 16)
                begin
                    wt = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
                end
                else
                begin
                    s0 = rotr(w[(t-15)&15], 7) ^ rotr(w[(t-15)&15], 18) ^ (w[(t-15)&15] >> 3);
                    s1 = rotr(w[(t-2)&15], 17) ^ rotr(w[(t-2)&15], 19) ^ (w[(t-2)&15] >> 10);
                    wt = w[t&15] + s0 + w[(t-7)&15] + s1;
                end
                w[t&15] = wt;
                t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                     + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::RoundK[t] + wt;
                t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                     + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6];
                v[6] = v[5];
                v[5] = v[4];
                v[4] = v[3] + t1;
                v[3] = v[2];
                v[2] = v[1];
                v[1] = v[0];
                v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++)
            begin
                hash_state[i] += v[i];
            end
        endfunction

        function void note_input(logic [7:0] b, logic present, logic eom);
            int unsigned pos;
            digest_rec_t r;
            if (present)
            begin
                blk[fill] = b;
                fill++;
                bit_count += 64'd8;
                if (fill == 64)
                begin
                    compress();
                    fill = 0;
                end
            end
            if (!eom)
            begin
                return;
            end
            pos = fill;
            blk[pos] = sha_pkg::PadByte;
            pos++;
            if (pos > 56)
            begin
                while (pos < 64)
                begin
                    blk[pos] = 8'h00;
                    pos++;
                end
                compress();
                pos = 0;
            end
            while (pos < 56)
            begin
                blk[pos] = 8'h00;
                pos++;
            end
            for (int i = 0; i < 8; i++)
            begin
                blk[56 + i] = bit_count[63 - 8*i -: 8];
            end
            compress();
            for (int k = 0; k < 4; k++)
            begin
                r.part = {hash_state[2*k], hash_state[2*k+1]};
                r.idx  = k[1:0];
                r.last = (k == 3);
                pending.push_back(r);
            end
            restart();
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        task check(logic [63:0] part, logic [1:0] idx, logic last);
            digest_rec_t e;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected digest part %h", part));
                return;
            end
            e = pending.pop_front();
            if (part !== e.part)
                report($sformatf("part %h, want %h", part, e.part));
            if (idx !== e.idx)
                report($sformatf("index %0d, want %0d", idx, e.idx));
            if (last !== e.last)
                report($sformatf("last %b, want %b", last, e.last));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = '0;
    logic        byte_present = 1'b0;
    logic        end_of_message = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] digest_part;
    logic [1:0]  part_index;
    logic        last_part;

    digest_board board = new();
    int unsigned cycles = 0;
    bit          calm = 1'b0;

    sha256_stream_hasher uut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 2_000_000)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check(digest_part, part_index, last_part);
        if (rst_n)
            out_stall <= !calm && ($urandom_range(99) < 31);
    end

    task automatic send(logic [7:0] b, logic present, logic eom);
        while (!calm && $urandom_range(99) < 31)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        byte_present <= present;
        end_of_message <= eom;
        do
            @(posedge clk);
        while (in_stall);
        board.note_input(b, present, eom);
    endtask

    task automatic send_message(int len);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(9) == 0)
                send(8'($urandom), 1'b0, 1'b0);
            send(8'($urandom), 1'b1, 1'b0);
        end
        send(8'($urandom), 1'b0, 1'b1);
    endtask

    initial
    begin
        int sent;
        int len;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: empty message, one byte with end, byte extremes, pad boundaries
        send(8'h00, 1'b0, 1'b1);
        send(8'hff, 1'b0, 1'b0);
        send(8'hff, 1'b1, 1'b1);
        send(8'h00, 1'b1, 1'b0);
        send(8'h5a, 1'b1, 1'b1);
        send_message(55);
        send_message(56);
        send_message(64);
        send_message(119);
        in_valid <= 1'b0;
        // hold off until every digest has arrived
        while (board.pending.size() != 0)
        begin
            @(posedge clk);
        end
        sent = 0;
        while (sent < 500)
        begin
            calm = (sent >= 200 && sent < 300);
            case ($urandom_range(3))
                0: len = $urandom_range(3);
                1: len = $urandom_range(70);
                2: len = 50 + $urandom_range(20);
                default: len = $urandom_range(130);
            endcase
            if ($urandom_range(9) == 0)
            begin
                send(8'($urandom), 1'b1, 1'b1);
                len = 1;
            end
            else
                send_message(len);
            sent += len + 1;
        end
        in_valid <= 1'b0;
        calm = 1'b0;
        while (board.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (200) @(posedge clk);
        if (board.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
